// File: hw/rtl/iml_pkg.sv
// Shared types and constants of the int8 matrix-vector layer.
`default_nettype none

package iml_pkg;

  // Input commands
  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_ACT    = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS = 2'd1;
  localparam int unsigned CFG_DATA_W = 10;

  // Register reset values
  localparam logic [9:0] INPUTS_RESET  = 10'd512;
  localparam logic [5:0] OUTPUTS_RESET = 6'd32;

  // One input item
  typedef struct packed {
    cmd_e               command;
    logic [4:0]         row_index;
    logic [8:0]         column_index;
    logic signed [7:0]  weight_value;
    logic signed [31:0] bias_value;
    logic [6:0]         activation_value;
    logic               last_activation;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [4:0]         output_row;
    logic signed [31:0] row_sum;
    logic               last_result;
  } out_item_t;

  // Sequencer to MAC control
  typedef struct packed {
    logic load_bias;
    logic mac_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/iml_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module iml_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]              wdata_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/iml_mac.sv
// Shared multiply-accumulate unit: loads a bias, then adds activation times weight.
`default_nettype none

module iml_mac
  import iml_pkg::*;
(
  input  wire logic               clk_i,
  input  wire mac_ctrl_t          ctrl_i,
  input  wire logic signed [31:0] bias_i,
  input  wire logic [6:0]         act_i,
  input  wire logic signed [7:0]  weight_i,
  output logic signed [31:0]      acc_o
);

  logic signed [15:0] prod;
  logic signed [31:0] acc_d, acc_q;

  // Unsigned activation times signed weight, exact in 16 bits
  assign prod = $signed({1'b0, act_i}) * weight_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.load_bias) begin
      acc_d = bias_i;
    end else if (ctrl_i.mac_en) begin
      acc_d = acc_q + 32'(prod);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// File: hw/rtl/iml_seq.sv
// Sequencer: configuration registers, row and column counters, result register.
`default_nettype none

module iml_seq
  import iml_pkg::*;
#(
  parameter int unsigned MAX_INPUTS  = 512,
  parameter int unsigned MAX_OUTPUTS = 32,
  localparam int unsigned CW = $clog2(MAX_INPUTS),
  localparam int unsigned RW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_item_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [RW-1:0]              bias_raddr_o,
  output logic [CW-1:0]              act_raddr_o,
  output logic [RW+CW-1:0]           weight_raddr_o,
  output mac_ctrl_t                  mac_ctrl_o,
  input  wire logic signed [31:0]    acc_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o
);

  localparam int unsigned NW = (CW + 1 > 10) ? CW + 1 : 10;
  localparam int unsigned OW = 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIAS,
    S_MAC,
    S_DRAIN,
    S_FIN
  } state_e;

  state_e     state_d, state_q;
  logic [RW-1:0] row_d, row_q;
  logic [CW-1:0] col_d, col_q;
  logic       load_d, load_q;
  logic       macv_d, macv_q;
  logic       ov_d, ov_q;
  out_item_t  oitem_d, oitem_q;
  logic [9:0] inputs_d, inputs_q;
  logic [5:0] outputs_d, outputs_q;

  logic [NW-1:0] n_raw, n_cap, n_rnd, n_min;
  logic [CW-1:0] cols_m1;
  logic [OW-1:0] r_raw, r_lim;
  logic [RW-1:0] rows_m1;

  // Effective column count: capped, rounded down to a multiple of 32, at least 32
  always_comb begin
    n_raw = NW'(inputs_q);
    n_cap = (n_raw > NW'(MAX_INPUTS)) ? NW'(MAX_INPUTS) : n_raw;
    n_rnd = n_cap & ~NW'(31);
    n_min = (n_rnd < NW'(32)) ? NW'(32) : n_rnd;
    cols_m1 = CW'(n_min - NW'(1));
  end

  // Effective row count: 1 .. MAX_OUTPUTS
  always_comb begin
    r_raw = {1'b0, outputs_q};
    r_lim = r_raw;
    if (r_raw == '0) begin
      r_lim = OW'(1);
    end else if (r_raw > OW'(MAX_OUTPUTS)) begin
      r_lim = OW'(MAX_OUTPUTS);
    end
    rows_m1 = RW'(r_lim - OW'(1));
  end

  // Next-state logic
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    load_d    = 1'b0;
    macv_d    = 1'b0;
    ov_d      = ov_q && !out_ready_i;
    oitem_d   = oitem_q;
    inputs_d  = inputs_q;
    outputs_d = outputs_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INPUTS:  inputs_d  = cfg_data_i[9:0];
        CFG_OUTPUTS: outputs_d = cfg_data_i[5:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_item_i.command == CMD_ACT && in_item_i.last_activation) begin
          state_d = S_BIAS;
          row_d   = '0;
        end
      end
      S_BIAS: begin
        load_d  = 1'b1;
        col_d   = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        macv_d = 1'b1;
        if (col_q == cols_m1) begin
          state_d = S_DRAIN;
        end else begin
          col_d = col_q + CW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        // hand the finished row to the output register once it is free
        if (!ov_q || out_ready_i) begin
          ov_d                = 1'b1;
          oitem_d.output_row  = 5'(row_q);
          oitem_d.row_sum     = acc_i;
          oitem_d.last_result = (row_q == rows_m1);
          if (row_q == rows_m1) begin
            state_d = S_IDLE;
          end else begin
            row_d   = row_q + RW'(1);
            state_d = S_BIAS;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      load_q    <= 1'b0;
      macv_q    <= 1'b0;
      ov_q      <= 1'b0;
      inputs_q  <= INPUTS_RESET;
      outputs_q <= OUTPUTS_RESET;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      load_q    <= load_d;
      macv_q    <= macv_d;
      ov_q      <= ov_d;
      inputs_q  <= inputs_d;
      outputs_q <= outputs_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    oitem_q <= oitem_d;
  end

  assign in_ready_o           = (state_q == S_IDLE);
  assign bias_raddr_o         = row_q;
  assign act_raddr_o          = col_q;
  assign weight_raddr_o       = {row_q, col_q};
  assign mac_ctrl_o.load_bias = load_q;
  assign mac_ctrl_o.mac_en    = macv_q;
  assign out_valid_o          = ov_q;
  assign out_item_o           = oitem_q;

endmodule

`default_nettype wire

// File: hw/rtl/int8_matrix_vector_layer.sv
// Top level of the int8 matrix-vector layer: stores, sequencer and shared MAC.
// Weight, bias and plain activation writes do not start an evaluation; ready stays high.
// An activation transfer marked last starts an evaluation, row by row:
// per row one bias read, one MAC step per column on the shared unit, one drain, one hand-off.
// Each row's result is offered once its hand-off finds the output register free; not ready meanwhile.
// Reset sets inputs_in_use to 512 and outputs_in_use to 32; stores are not cleared.
`default_nettype none

module int8_matrix_vector_layer
  import iml_pkg::*;
#(
  parameter int unsigned MAX_INPUTS  = 512,
  parameter int unsigned MAX_OUTPUTS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_INPUTS);
  localparam int unsigned RW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int unsigned WDEPTH = 1 << (RW + CW);

  logic       xfer;
  logic       row_ok, col_ok;
  logic       w_we, b_we, a_we;
  logic [RW-1:0]    bias_raddr;
  logic [CW-1:0]    act_raddr;
  logic [RW+CW-1:0] weight_raddr;
  logic signed [31:0] bias_rdata;
  logic [6:0]         act_rdata;
  logic signed [7:0]  weight_rdata;
  logic signed [31:0] acc;
  mac_ctrl_t          mac_ctrl;

  // Store write decode; out-of-range addresses drop the write
  assign xfer   = in_valid_i && in_ready_o;
  assign row_ok = {2'b00, in_item_i.row_index} < 7'(MAX_OUTPUTS);
  assign col_ok = {4'b0000, in_item_i.column_index} < 13'(MAX_INPUTS);

  always_comb begin
    w_we = 1'b0;
    b_we = 1'b0;
    a_we = 1'b0;
    case (in_item_i.command)
      CMD_WEIGHT: w_we = xfer && row_ok && col_ok;
      CMD_BIAS:   b_we = xfer && row_ok;
      CMD_ACT:    a_we = xfer && col_ok;
      default: ;
    endcase
  end

  iml_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i ({RW'(in_item_i.row_index), CW'(in_item_i.column_index)}),
    .wdata_i (in_item_i.weight_value),
    .raddr_i (weight_raddr),
    .rdata_o (weight_rdata)
  );

  iml_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (RW'(in_item_i.row_index)),
    .wdata_i (in_item_i.bias_value),
    .raddr_i (bias_raddr),
    .rdata_o (bias_rdata)
  );

  iml_ram #(.WIDTH(7), .DEPTH(MAX_INPUTS)) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (CW'(in_item_i.column_index)),
    .wdata_i (in_item_i.activation_value),
    .raddr_i (act_raddr),
    .rdata_o (act_rdata)
  );

  iml_seq #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_item_i      (in_item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .bias_raddr_o   (bias_raddr),
    .act_raddr_o    (act_raddr),
    .weight_raddr_o (weight_raddr),
    .mac_ctrl_o     (mac_ctrl),
    .acc_i          (acc),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_o     (out_item_o)
  );

  iml_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .bias_i   (bias_rdata),
    .act_i    (act_rdata),
    .weight_i (weight_rdata),
    .acc_o    (acc)
  );

endmodule

`default_nettype wire
